/* hdl/cmc_pkg.sv */
package cmc_pkg;

	// Command codes carried in the op field.
	typedef enum logic [2:0] {
		OP_SET         = 3'd0,
		OP_RESUME      = 3'd1,
		OP_STOP        = 3'd2,
		OP_ACCEL_START = 3'd3,
		OP_ACCEL_END   = 3'd4,
		OP_SUSPEND     = 3'd5
	} op_t;

	// Display message codes.
	typedef enum logic [2:0] {
		MSG_NONE        = 3'd0,
		MSG_SPEED       = 3'd1,
		MSG_DEACTIVATED = 3'd2,
		MSG_ACCEL       = 3'd3,
		MSG_SUSPENDED   = 3'd4
	} msg_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_MIN_SPEED      = 2'd0,
		REG_MAX_SPEED      = 2'd1,
		REG_ACCEL_SETPOINT = 2'd2,
		REG_CRUISE_GEAR    = 2'd3
	} reg_idx_t;

	localparam int SPEED_W = 8;
	localparam int GEAR_W  = 3;
	localparam int OP_W    = 3;
	localparam int MSG_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [SPEED_W-1:0] MIN_SPEED_RST      = 8'd80;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST      = 8'd130;
	localparam logic [SPEED_W-1:0] ACCEL_SETPOINT_RST = 8'd130;
	localparam logic [GEAR_W-1:0]  CRUISE_GEAR_RST    = 3'd5;

	typedef struct packed {
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] max_speed;
		logic [SPEED_W-1:0] accel_setpoint;
		logic [GEAR_W-1:0]  cruise_gear;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic               calibrating;
		logic               ignition_on;
		logic               brake_pressed;
		logic               clutch_pressed;
		logic [GEAR_W-1:0]  gear;
		logic [SPEED_W-1:0] current_speed;
	} item_t;

	typedef struct packed {
		logic               active;
		logic               suspended;
		logic               accelerating;
		logic [SPEED_W-1:0] cruise_speed;
		logic               led;
	} state_t;

	typedef struct packed {
		logic               setpoint_write;
		logic [SPEED_W-1:0] setpoint;
		logic [MSG_W-1:0]   message;
		logic [SPEED_W-1:0] shown_speed;
		logic               led;
		logic               is_active;
		logic               is_suspended;
		logic [SPEED_W-1:0] held_speed;
	} result_t;

endpackage

/* hdl/cmc_if.sv */
interface cmc_in_if;
	import cmc_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic               calibrating;
	logic               ignition_on;
	logic               brake_pressed;
	logic               clutch_pressed;
	logic [GEAR_W-1:0]  gear;
	logic [SPEED_W-1:0] current_speed;

	modport source (
		output valid, op, calibrating, ignition_on, brake_pressed, clutch_pressed,
		       gear, current_speed,
		input  ready
	);
	modport sink (
		input  valid, op, calibrating, ignition_on, brake_pressed, clutch_pressed,
		       gear, current_speed,
		output ready
	);
endinterface

interface cmc_out_if;
	import cmc_pkg::*;

	logic               valid;
	logic               ready;
	logic               setpoint_write;
	logic [SPEED_W-1:0] setpoint;
	logic [MSG_W-1:0]   message;
	logic [SPEED_W-1:0] shown_speed;
	logic               led;
	logic               is_active;
	logic               is_suspended;
	logic [SPEED_W-1:0] held_speed;

	modport source (
		output valid, setpoint_write, setpoint, message, shown_speed, led,
		       is_active, is_suspended, held_speed,
		input  ready
	);
	modport sink (
		input  valid, setpoint_write, setpoint, message, shown_speed, led,
		       is_active, is_suspended, held_speed,
		output ready
	);
endinterface

/* hdl/cruise_mode_controller.sv */
// Cruise mode controller: one driver command plus a sensor snapshot per transaction.
// Each accepted command passes through the input register and then the output register before its result is offered.
// Throughput: one transaction per cycle while the output is not stalled; the mode state is updated
// when a command leaves the input register and fed straight back to the next command held there.
// Reset: arst_n clears all flags, the held speed and the LED, and loads the
// configuration registers with their defaults; no transaction is in flight after reset.
module cruise_mode_controller
	import cmc_pkg::*;
#(
	parameter logic [SPEED_W-1:0] MinSpeedRst     = MIN_SPEED_RST,
	parameter logic [SPEED_W-1:0] MaxSpeedRst     = MAX_SPEED_RST,
	parameter logic [SPEED_W-1:0] AccelSetRst     = ACCEL_SETPOINT_RST,
	parameter logic [GEAR_W-1:0]  CruiseGearRst   = CRUISE_GEAR_RST
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cmc_in_if.sink                in_ch,
	cmc_out_if.source             out_ch
);

	// Configuration registers. Writes must arrive only while no transaction is in flight; the block
	// does not enforce this, and there is no interlock against the datapath.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_speed      <= MinSpeedRst;
			cfg_q.max_speed      <= MaxSpeedRst;
			cfg_q.accel_setpoint <= AccelSetRst;
			cfg_q.cruise_gear    <= CruiseGearRst;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_MIN_SPEED:      cfg_q.min_speed      <= cfg_data;
				REG_MAX_SPEED:      cfg_q.max_speed      <= cfg_data;
				REG_ACCEL_SETPOINT: cfg_q.accel_setpoint <= cfg_data;
				REG_CRUISE_GEAR:    cfg_q.cruise_gear    <= cfg_data[GEAR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register stage. The item held here is evaluated against the mode
	// state; it moves on when the output register is empty or being emptied.
	logic    valid_s1;
	item_t   item_s1;
	logic    adv_s1;
	logic    out_valid_q;
	result_t out_q;

	assign adv_s1       = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.op             <= in_ch.op;
			item_s1.calibrating    <= in_ch.calibrating;
			item_s1.ignition_on    <= in_ch.ignition_on;
			item_s1.brake_pressed  <= in_ch.brake_pressed;
			item_s1.clutch_pressed <= in_ch.clutch_pressed;
			item_s1.gear           <= in_ch.gear;
			item_s1.current_speed  <= in_ch.current_speed;
		end
	end

	// Mode state and the command decision.
	state_t  state_q;
	state_t  state_nxt;
	result_t result;

	cmc_step u_step (
		.item      (item_s1),
		.state     (state_q),
		.cfg       (cfg_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	// The state commits exactly when the command leaves the input register, so
	// the following command already sees the updated mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register: holds a finished result until the sink takes it, while
	// the input register keeps accepting as long as this register drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= result;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.setpoint_write = out_q.setpoint_write;
	assign out_ch.setpoint       = out_q.setpoint;
	assign out_ch.message        = out_q.message;
	assign out_ch.shown_speed    = out_q.shown_speed;
	assign out_ch.led            = out_q.led;
	assign out_ch.is_active      = out_q.is_active;
	assign out_ch.is_suspended   = out_q.is_suspended;
	assign out_ch.held_speed     = out_q.held_speed;

	// An acceleration request only exists inside an engaged, suspended cruise.
	a_accel_in_cruise: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.accelerating |-> (state_q.active && state_q.suspended))
		else $error("accelerating flag set outside an engaged, suspended cruise");

	// The indicator LED follows the active flag at all times.
	a_led_tracks_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.led == state_q.active)
		else $error("LED state disagrees with the active flag");

	// A command leaving the input register always shows up as a result.
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("advanced command did not produce a result");

	// A speed message always reports an engaged, unsuspended cruise at the held speed.
	a_speed_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.message == MSG_SPEED) |->
			(out_q.is_active && !out_q.is_suspended && out_q.shown_speed == out_q.held_speed))
		else $error("speed message without an engaged cruise");

endmodule

/* hdl/cmc_step.sv */
// Next-state and result logic for one command against the current mode state.
module cmc_step
	import cmc_pkg::*;
(
	input  item_t   item,
	input  state_t  state,
	input  cfg_t    cfg,
	output state_t  state_nxt,
	output result_t result
);

	logic   req_ok;
	logic   do_engage;
	logic   capture;
	logic   wr;
	logic [SPEED_W-1:0] wr_val;
	msg_t   msg;
	state_t nxt;

	assign req_ok = !item.calibrating && item.ignition_on && !item.brake_pressed
		&& !item.clutch_pressed && (item.gear == cfg.cruise_gear)
		&& (item.current_speed >= cfg.min_speed) && (item.current_speed <= cfg.max_speed);

	always_comb begin
		nxt       = state;
		wr        = 1'b0;
		wr_val    = '0;
		msg       = MSG_NONE;
		do_engage = 1'b0;
		capture   = 1'b0;

		unique case (op_t'(item.op))
			OP_SET: begin
				do_engage = req_ok;
				capture   = 1'b1;
			end
			OP_RESUME: begin
				do_engage = req_ok;
			end
			OP_STOP: begin
				if (state.active) begin
					wr               = 1'b1;
					nxt.cruise_speed = '0;
					nxt.active       = 1'b0;
					nxt.suspended    = 1'b0;
					nxt.accelerating = 1'b0;
					nxt.led          = 1'b0;
					msg              = MSG_DEACTIVATED;
				end
			end
			OP_ACCEL_START: begin
				if (state.active && !state.suspended) begin
					nxt.accelerating = 1'b1;
					nxt.suspended    = 1'b1;
					wr               = 1'b1;
					wr_val           = cfg.accel_setpoint;
					msg              = MSG_ACCEL;
				end
			end
			OP_ACCEL_END: begin
				if (state.active) begin
					nxt.accelerating = 1'b0;
					do_engage        = req_ok;
					capture          = 1'b1;
				end
			end
			OP_SUSPEND: begin
				if (state.active) begin
					nxt.suspended = 1'b1;
					wr            = 1'b1;
					msg           = MSG_SUSPENDED;
				end
			end
			default: begin
			end
		endcase

		// Engagement: optionally capture the current speed, then hold it.
		if (do_engage) begin
			if (capture) begin
				nxt.cruise_speed = item.current_speed;
			end
			wr               = 1'b1;
			wr_val           = nxt.cruise_speed;
			nxt.active       = 1'b1;
			nxt.suspended    = 1'b0;
			nxt.accelerating = 1'b0;
			nxt.led          = 1'b1;
			msg              = MSG_SPEED;
		end
	end

	assign state_nxt             = nxt;
	assign result.setpoint_write = wr;
	assign result.setpoint       = wr_val;
	assign result.message        = msg;
	assign result.shown_speed    = (msg == MSG_SPEED) ? nxt.cruise_speed : '0;
	assign result.led            = nxt.led;
	assign result.is_active      = nxt.active;
	assign result.is_suspended   = nxt.suspended;
	assign result.held_speed     = nxt.cruise_speed;

endmodule
